>>> hw/rtl/bankers_safety_allocator_macros.svh
// ============================================================================
// Assertion macros for the banker's safety allocator
// Shorthand for clocked assertions that are disabled during reset.
// ============================================================================
`ifndef BANKERS_SAFETY_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bsa_pkg.sv
// ============================================================================
// bsa_pkg
// Shared codes, item layout and controller/datapath signal groups.
// ============================================================================
package bsa_pkg;

  localparam int CMD_W = 2;
  localparam int PID_W = 3;
  localparam int AMT_W = 8;
  localparam int ST_W  = 3;
  localparam int SLOTS = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_AVAIL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQ   = 2'd2;

  localparam logic [ST_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [ST_W-1:0] ST_OVER_NEED = 3'd1;
  localparam logic [ST_W-1:0] ST_OVER_AVL  = 3'd2;
  localparam logic [ST_W-1:0] ST_UNSAFE    = 3'd3;
  localparam logic [ST_W-1:0] ST_LOADED    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic [PID_W-1:0]            process_id;
    logic [SLOTS-1:0][AMT_W-1:0] amount;
    logic [SLOTS-1:0][AMT_W-1:0] need;
  } cmd_item_t;

  typedef struct packed {
    logic            capture;
    logic            write_row;
    logic            write_avail;
    logic            fetch;
    logic            scan_read;
    logic            scan_skip;
    logic            check_step;
    logic            commit;
    logic            set_status;
    logic [ST_W-1:0] code;
    logic            emit;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             over_need;
    logic             over_avail;
    logic             scan_end;
    logic             row_done;
    logic             all_done;
    logic             out_busy;
  } sts_t;

endpackage

>>> hw/rtl/bsa_cmd_if.sv
// ============================================================================
// bsa_cmd_if
// Command channel: valid/ready handshake with one command item.
// ============================================================================
interface bsa_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] process_id;
  logic [7:0] amount_0;
  logic [7:0] amount_1;
  logic [7:0] amount_2;
  logic [7:0] need_0;
  logic [7:0] need_1;
  logic [7:0] need_2;

  modport source (
    output valid, command, process_id, amount_0, amount_1, amount_2,
           need_0, need_1, need_2,
    input  ready
  );
  modport sink (
    input  valid, command, process_id, amount_0, amount_1, amount_2,
           need_0, need_1, need_2,
    output ready
  );
endinterface

>>> hw/rtl/bsa_rsp_if.sv
// ============================================================================
// bsa_rsp_if
// Result channel: valid/ready handshake with one result item.
// ============================================================================
interface bsa_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] free_0;
  logic [7:0] free_1;
  logic [7:0] free_2;

  modport source (
    output valid, status, free_0, free_1, free_2,
    input  ready
  );
  modport sink (
    input  valid, status, free_0, free_1, free_2,
    output ready
  );
endinterface

>>> hw/rtl/bsa_ram.sv
// ============================================================================
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bsa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/bsa_ctrl.sv
// ============================================================================
// bsa_ctrl
// Sequencer: decodes each command and steps the safety scan.
// ============================================================================
module bsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bsa_pkg::sts_t sts,
  output bsa_pkg::ctl_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.set_status = 1'b1;
        ctl.code       = bsa_pkg::ST_LOADED;
        state_next     = S_FINISH;
        unique case (sts.command)
          bsa_pkg::CMD_LOAD: begin
            ctl.write_row = 1'b1;
          end
          bsa_pkg::CMD_AVAIL: begin
            ctl.write_avail = 1'b1;
          end
          bsa_pkg::CMD_REQ: begin
            priority if (sts.over_need) begin
              ctl.code = bsa_pkg::ST_OVER_NEED;
            end else if (sts.over_avail) begin
              ctl.code = bsa_pkg::ST_OVER_AVL;
            end else begin
              ctl.set_status = 1'b0;
              ctl.fetch      = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts.scan_end) begin
          ctl.set_status = 1'b1;
          if (sts.all_done) begin
            ctl.commit = 1'b1;
            ctl.code   = bsa_pkg::ST_GRANTED;
          end else begin
            ctl.code = bsa_pkg::ST_UNSAFE;
          end
          state_next = S_FINISH;
        end else if (sts.row_done) begin
          ctl.scan_skip = 1'b1;
        end else begin
          ctl.scan_read = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.check_step = 1'b1;
        state_next     = S_SCAN;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/bsa_dpath.sv
// ============================================================================
// bsa_dpath
// Tables, available vector, tentative grant, safety scan and result register.
// ============================================================================
module bsa_dpath #(
  parameter int PROCESSES  = 8,
  parameter int RESOURCES  = 3,
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  bsa_pkg::ctl_t     ctl,
  output bsa_pkg::sts_t     sts,
  input  bsa_pkg::cmd_item_t item,
  bsa_rsp_if.source         rsp
);

  localparam int IW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PW = $clog2(PROCESSES + 1);
  localparam int RW = RESOURCES * COUNT_BITS;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  cnt_t avail     [RESOURCES];
  cnt_t amt       [RESOURCES];
  cnt_t need      [RESOURCES];
  cnt_t t_alloc   [RESOURCES];
  cnt_t t_need    [RESOURCES];
  cnt_t work      [RESOURCES];
  cnt_t item_amt  [RESOURCES];
  cnt_t item_need [RESOURCES];
  cnt_t row_alloc [RESOURCES];
  cnt_t row_need  [RESOURCES];
  cnt_t chk_alloc [RESOURCES];
  cnt_t chk_need  [RESOURCES];

  logic [bsa_pkg::CMD_W-1:0] cmd_code;
  logic [bsa_pkg::PID_W-1:0] pid;
  logic                      pid_ok;
  logic [PROCESSES-1:0]      done;
  logic [PROCESSES-1:0]      row_valid;
  logic [PW-1:0]             p;
  logic [IW-1:0]             p_idx;
  logic [IW-1:0]             pid_idx;
  logic [IW-1:0]             rd_addr;
  logic                      rd_en;
  logic                      rd_in_range;
  logic                      rd_ok;
  logic                      wr_en;
  logic [RW-1:0]             wr_alloc;
  logic [RW-1:0]             wr_need;
  logic [RW-1:0]             ram_alloc;
  logic [RW-1:0]             ram_need;
  logic                      own_row;
  logic                      fits;
  logic                      over_need;
  logic                      over_avail;
  logic [bsa_pkg::ST_W-1:0]  res_status;
  logic                      out_valid;
  logic [bsa_pkg::ST_W-1:0]  out_status;
  logic [bsa_pkg::AMT_W-1:0] out_free [bsa_pkg::SLOTS];
  logic [bsa_pkg::AMT_W-1:0] free_now [bsa_pkg::SLOTS];

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  assign p_idx   = p[IW-1:0];
  assign pid_idx = IW'(pid);
  assign own_row = pid_ok && (int'(p) == int'(pid));

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      item_amt[r]  = COUNT_BITS'(item.amount[r]);
      item_need[r] = COUNT_BITS'(item.need[r]);
      row_alloc[r] = rd_ok ? ram_alloc[r*COUNT_BITS +: COUNT_BITS] : '0;
      row_need[r]  = rd_ok ? ram_need[r*COUNT_BITS +: COUNT_BITS] : '0;
      chk_alloc[r] = own_row ? t_alloc[r] : row_alloc[r];
      chk_need[r]  = own_row ? t_need[r] : row_need[r];
    end
  end

  always_comb begin
    over_need  = 1'b0;
    over_avail = 1'b0;
    fits       = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      if (amt[r] > row_need[r]) begin
        over_need = 1'b1;
      end
      if (amt[r] > avail[r]) begin
        over_avail = 1'b1;
      end
      if (chk_need[r] > work[r]) begin
        fits = 1'b0;
      end
    end
  end

  // Table port: the requesting row at capture, otherwise the scanned row.
  assign rd_en       = ctl.capture || ctl.scan_read;
  assign rd_addr     = ctl.capture ? IW'(item.process_id) : p_idx;
  assign rd_in_range = ctl.capture ? (int'(item.process_id) < PROCESSES) : 1'b1;
  assign wr_en       = (ctl.write_row || ctl.commit) && pid_ok;

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      wr_alloc[r*COUNT_BITS +: COUNT_BITS] = ctl.write_row ? amt[r] : t_alloc[r];
      wr_need[r*COUNT_BITS +: COUNT_BITS]  = ctl.write_row ? need[r] : t_need[r];
    end
  end

  bsa_ram #(
    .WIDTH (RW),
    .DEPTH (PROCESSES)
  ) u_alloc_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pid_idx),
    .wr_data (wr_alloc),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_alloc)
  );

  bsa_ram #(
    .WIDTH (RW),
    .DEPTH (PROCESSES)
  ) u_need_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pid_idx),
    .wr_data (wr_need),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_need)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < RESOURCES; r++) begin
        avail[r] <= '0;
      end
    end else begin
      if (wr_en) begin
        row_valid[pid_idx] <= 1'b1;
      end
      for (int r = 0; r < RESOURCES; r++) begin
        if (ctl.write_avail) begin
          avail[r] <= amt[r];
        end else if (ctl.commit) begin
          avail[r] <= avail[r] - amt[r];
        end
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_code <= item.command;
      pid      <= item.process_id;
      pid_ok   <= int'(item.process_id) < PROCESSES;
      amt      <= item_amt;
      need     <= item_need;
    end
    if (rd_en) begin
      rd_ok <= rd_in_range && row_valid[rd_addr];
    end
    if (ctl.fetch) begin
      done <= '0;
      p    <= '0;
      for (int r = 0; r < RESOURCES; r++) begin
        t_alloc[r] <= sat_add(row_alloc[r], amt[r]);
        t_need[r]  <= row_need[r] - amt[r];
        work[r]    <= avail[r] - amt[r];
      end
    end else if (ctl.scan_skip) begin
      p <= p + 1'b1;
    end else if (ctl.check_step) begin
      if (fits) begin
        done[p_idx] <= 1'b1;
        p           <= '0;
        for (int r = 0; r < RESOURCES; r++) begin
          work[r] <= sat_add(work[r], chk_alloc[r]);
        end
      end else begin
        p <= p + 1'b1;
      end
    end
    if (ctl.set_status) begin
      res_status <= ctl.code;
    end
    if (ctl.emit) begin
      out_status <= res_status;
      out_free   <= free_now;
    end
  end

  for (genvar j = 0; j < bsa_pkg::SLOTS; j++) begin : g_free
    if (j < RESOURCES) begin : g_used
      assign free_now[j] = bsa_pkg::AMT_W'(avail[j]);
    end else begin : g_unused
      assign free_now[j] = '0;
    end
  end

  assign sts.command    = cmd_code;
  assign sts.over_need  = over_need;
  assign sts.over_avail = over_avail;
  assign sts.scan_end   = (p == PW'(PROCESSES));
  assign sts.row_done   = !sts.scan_end && done[p_idx];
  assign sts.all_done   = &done;
  assign sts.out_busy   = out_valid && !rsp.ready;

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.free_0 = out_free[0];
  assign rsp.free_1 = out_free[1];
  assign rsp.free_2 = out_free[2];

endmodule

>>> hw/rtl/bankers_safety_allocator.sv
// ============================================================================
// bankers_safety_allocator
// Banker's algorithm allocator: row loads, available vector, safe requests.
// ============================================================================
//   Channel  Role    Carries
//   cmd      sink    command, process_id, amount_0..2, need_0..2
//   rsp      source  status, free_0..2
//
// Loads, available writes, unknown commands and refused requests skip the scan.
// A request that reaches the safety check scans the rows: an unfinished row costs
// a table read and a compare, a finished row one skip, and the scan restarts after
// every reclaimed row.
// Reset marks every table row empty and clears the available vector.
// A new command is accepted while the previous result waits on rsp.
module bankers_safety_allocator #(
  parameter int PROCESSES  = 8,
  parameter int RESOURCES  = 3,
  parameter int COUNT_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  bsa_cmd_if.sink   cmd,
  bsa_rsp_if.source rsp
);

  bsa_pkg::ctl_t      ctl;
  bsa_pkg::sts_t      sts;
  bsa_pkg::cmd_item_t item;
  logic               ready;

  assign item.command    = cmd.command;
  assign item.process_id = cmd.process_id;
  assign item.amount[0]  = cmd.amount_0;
  assign item.amount[1]  = cmd.amount_1;
  assign item.amount[2]  = cmd.amount_2;
  assign item.need[0]    = cmd.need_0;
  assign item.need[1]    = cmd.need_1;
  assign item.need[2]    = cmd.need_2;
  assign cmd.ready       = ready;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bsa_dpath #(
    .PROCESSES  (PROCESSES),
    .RESOURCES  (RESOURCES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .sts  (sts),
    .item (item),
    .rsp  (rsp)
  );

endmodule

>>> hw/rtl/bsa_checker.sv
// ============================================================================
// bsa_checker
// Port-level checks on the allocator, bound to its top level.
// ============================================================================
`include "bankers_safety_allocator_macros.svh"

module bsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status
);

  // A command item is worked on alone, so acceptance closes the port.
  `BSA_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")

  `BSA_ASSERT_SAME(a_status_code, rsp_valid, rsp_status <= bsa_pkg::ST_LOADED, "bad status code")

  `BSA_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

  `BSA_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_status), "status moved")

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status)
);
